// ===== rtl/core/vhc_pkg.sv =====
package vhc_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_BAD_MAJOR = 3'd2,
		ST_BAD_CRC   = 3'd3,
		ST_BAD_MINOR = 3'd4,
		ST_BAD_SIZE  = 3'd5
	} status_t;

	typedef enum logic {
		REG_SIZE_MIN = 1'b0,
		REG_SIZE_MAX = 1'b1
	} reg_idx_t;

	localparam logic [31:0] SIZE_MIN_RESET = 32'd1;
	localparam logic [31:0] SIZE_MAX_RESET = 32'd16777216;

	localparam logic [7:0] MAGIC [4] = '{8'h42, 8'h43, 8'h46, 8'h00};

	localparam logic [3:0] POS_MAJOR     = 4'd4;
	localparam logic [3:0] POS_MINOR     = 4'd5;
	localparam logic [3:0] POS_SIZE_LO   = 4'd8;
	localparam logic [3:0] POS_CRC_LO    = 4'd12;
	localparam logic [3:0] POS_LAST      = 4'd15;

	localparam logic [7:0]  MAJOR_SUPPORTED = 8'd1;
	localparam logic [7:0]  MINOR_SUPPORTED = 8'd0;
	localparam logic [4:0]  HDR_LEN         = 5'd16;
	localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;

	typedef struct packed {
		logic       fire;
		logic       start;
		logic [7:0] data;
	} step_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  major_version;
		logic [7:0]  minor_version;
		logic [31:0] payload_size;
		logic [4:0]  bytes_consumed;
	} result_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/vhc_byte_if.sv =====
interface vhc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== rtl/core/vhc_result_if.sv =====
interface vhc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  major_version;
	logic [7:0]  minor_version;
	logic [31:0] payload_size;
	logic [4:0]  bytes_consumed;

	modport source (output valid, output status, output major_version, output minor_version,
		output payload_size, output bytes_consumed, input ready);
	modport sink (input valid, input status, input major_version, input minor_version,
		input payload_size, input bytes_consumed, output ready);
endinterface

// ===== rtl/core/vhc_parse_core.sv =====
module vhc_parse_core (
	input  logic             clk,
	input  logic             arst_n,
	input  vhc_pkg::step_t   step,
	input  logic [31:0]      size_min,
	input  logic [31:0]      size_max,
	output logic             emit,
	output vhc_pkg::result_t result
);

	logic [3:0]  pos_q;
	logic        done_q;
	logic [31:0] crc_q;
	logic [7:0]  major_q;
	logic [7:0]  minor_q;
	logic [31:0] size_q;
	logic [31:0] rcrc_q;

	logic [3:0]  pos_c;
	logic        done_c;
	logic [31:0] crc_c;
	logic [7:0]  major_c;
	logic [7:0]  minor_c;
	logic [31:0] size_c;
	logic [31:0] rcrc_c;

	logic [3:0]  pos_n;
	logic        done_n;
	logic [31:0] crc_n;
	logic [7:0]  major_n;
	logic [7:0]  minor_n;
	logic [31:0] size_n;
	logic [31:0] rcrc_n;
	vhc_pkg::status_t status_n;

	always_comb begin
		// A start flag restarts the header before this byte is looked at.
		if (step.start) begin
			pos_c   = '0;
			done_c  = 1'b0;
			crc_c   = vhc_pkg::CRC_INIT;
			major_c = '0;
			minor_c = '0;
			size_c  = '0;
			rcrc_c  = '0;
		end else begin
			pos_c   = pos_q;
			done_c  = done_q;
			crc_c   = crc_q;
			major_c = major_q;
			minor_c = minor_q;
			size_c  = size_q;
			rcrc_c  = rcrc_q;
		end

		pos_n    = pos_c;
		done_n   = done_c;
		crc_n    = crc_c;
		major_n  = major_c;
		minor_n  = minor_c;
		size_n   = size_c;
		rcrc_n   = rcrc_c;
		status_n = vhc_pkg::ST_OK;
		emit     = 1'b0;

		if (!done_c) begin
			if (pos_c < vhc_pkg::POS_CRC_LO) begin
				crc_n = vhc_pkg::crc32_byte(crc_c, step.data);
			end
			if (pos_c < vhc_pkg::POS_MAJOR) begin
				if (step.data != vhc_pkg::MAGIC[pos_c[1:0]]) begin
					emit     = 1'b1;
					status_n = vhc_pkg::ST_BAD_MAGIC;
				end
			end else if (pos_c == vhc_pkg::POS_MAJOR) begin
				major_n = step.data;
				if (step.data != vhc_pkg::MAJOR_SUPPORTED) begin
					emit     = 1'b1;
					status_n = vhc_pkg::ST_BAD_MAJOR;
				end
			end else if (pos_c == vhc_pkg::POS_MINOR) begin
				minor_n = step.data;
			end else if (pos_c >= vhc_pkg::POS_SIZE_LO && pos_c < vhc_pkg::POS_CRC_LO) begin
				unique case (pos_c[1:0])
					2'd0: size_n[7:0]   = step.data;
					2'd1: size_n[15:8]  = step.data;
					2'd2: size_n[23:16] = step.data;
					default: size_n[31:24] = step.data;
				endcase
			end else if (pos_c >= vhc_pkg::POS_CRC_LO) begin
				unique case (pos_c[1:0])
					2'd0: rcrc_n[7:0]   = step.data;
					2'd1: rcrc_n[15:8]  = step.data;
					2'd2: rcrc_n[23:16] = step.data;
					default: rcrc_n[31:24] = step.data;
				endcase
				if (pos_c == vhc_pkg::POS_LAST) begin
					emit = 1'b1;
					priority if (rcrc_n != ~crc_c) begin
						status_n = vhc_pkg::ST_BAD_CRC;
					end else if (minor_c != vhc_pkg::MINOR_SUPPORTED) begin
						status_n = vhc_pkg::ST_BAD_MINOR;
					end else if (size_c < size_min || size_c > size_max) begin
						status_n = vhc_pkg::ST_BAD_SIZE;
					end else begin
						status_n = vhc_pkg::ST_OK;
					end
				end
			end
			if (emit) begin
				done_n = 1'b1;
			end else begin
				pos_n = pos_c + 4'd1;
			end
		end

		result.status         = status_n;
		result.major_version  = major_n;
		result.minor_version  = minor_n;
		result.payload_size   = (status_n == vhc_pkg::ST_OK) ? size_c : '0;
		result.bytes_consumed = (status_n == vhc_pkg::ST_OK) ? vhc_pkg::HDR_LEN : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			done_q  <= 1'b1;
			crc_q   <= vhc_pkg::CRC_INIT;
			major_q <= '0;
			minor_q <= '0;
			size_q  <= '0;
			rcrc_q  <= '0;
		end else if (step.fire) begin
			pos_q   <= pos_n;
			done_q  <= done_n;
			crc_q   <= crc_n;
			major_q <= major_n;
			minor_q <= minor_n;
			size_q  <= size_n;
			rcrc_q  <= rcrc_n;
		end
	end

endmodule

// ===== rtl/core/versioned_header_checker.sv =====
// Channel  Direction  Payload                                              Accepted when
// hdr      in         data_byte, frame_start                               valid && ready
// res      out        status, major_version, minor_version,                valid && ready
//                     payload_size, bytes_consumed
// cfg      in         cfg_idx, cfg_wdata (0 size min, 1 size max)          cfg_we
//
// One byte is taken every cycle unless a waiting result stalls the input register.
// The byte passes an input register, then the CRC update, field capture and checks run
// combinationally into the result register.
// A waiting result stalls the input register only when the result is not being taken.
// Reset leaves the checker waiting for a start flag with the default size bounds.
module versioned_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	vhc_byte_if.sink    hdr,
	vhc_result_if.source res,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic [31:0] size_min_q;
	logic [31:0] size_max_q;

	logic        v_s1;
	logic [7:0]  data_s1;
	logic        start_s1;

	logic             out_v_q;
	vhc_pkg::result_t res_q;

	logic             adv;
	logic             emit;
	vhc_pkg::step_t   step;
	vhc_pkg::result_t result;

	assign adv       = !out_v_q || res.ready;
	assign hdr.ready = !v_s1 || adv;

	assign step.fire  = v_s1 && adv;
	assign step.start = start_s1;
	assign step.data  = data_s1;

	vhc_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.size_min (size_min_q),
		.size_max (size_max_q),
		.emit     (emit),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_min_q <= vhc_pkg::SIZE_MIN_RESET;
			size_max_q <= vhc_pkg::SIZE_MAX_RESET;
		end else if (cfg_we) begin
			unique case (vhc_pkg::reg_idx_t'(cfg_idx))
				vhc_pkg::REG_SIZE_MIN: size_min_q <= cfg_wdata;
				vhc_pkg::REG_SIZE_MAX: size_max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (hdr.ready) begin
			v_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.ready && hdr.valid) begin
			data_s1  <= hdr.data_byte;
			start_s1 <= hdr.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= step.fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire && emit) begin
			res_q <= result;
		end
	end

	assign res.valid          = out_v_q;
	assign res.status         = res_q.status;
	assign res.major_version  = res_q.major_version;
	assign res.minor_version  = res_q.minor_version;
	assign res.payload_size   = res_q.payload_size;
	assign res.bytes_consumed = res_q.bytes_consumed;

endmodule

// ===== test/tb_versioned_header_checker.sv =====
module tb_versioned_header_checker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} hdr_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [31:0] cfg_wdata;

	vhc_byte_if   hdr ();
	vhc_result_if res ();

	versioned_header_checker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr       (hdr),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	logic [31:0] bound_lo;
	logic [31:0] bound_hi;
	logic [4:0]  hdr_pos;
	logic        hdr_idle;
	logic [31:0] crc_run;
	logic [31:0] crc_seen;
	logic [31:0] size_seen;
	logic [7:0]  major_seen;
	logic [7:0]  minor_seen;

	vhc_pkg::result_t awaited_verdicts [$];
	hdr_byte_t        byte_queue [$];
	hdr_byte_t        next_byte;
	vhc_pkg::result_t want;
	logic [7:0]       frame_bytes [16];
	int               queued_bytes;
	int               fail_count;
	int               gap_left;
	bit               calm_in;
	int               stall_left;
	bit               calm_out;
	int               idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		int          k;
		r = acc;
		for (k = 0; k < 8; k++) begin
			if (r[0] ^ b[k]) begin
				r = (r >> 1) ^ vhc_pkg::CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	function automatic void track_header_byte(input logic start, input logic [7:0] b);
		vhc_pkg::result_t v;
		logic             emit;
		int               p;
		if (start) begin
			hdr_pos    = '0;
			hdr_idle   = 1'b0;
			crc_run    = vhc_pkg::CRC_INIT;
			major_seen = '0;
			minor_seen = '0;
			size_seen  = '0;
			crc_seen   = '0;
		end
		if (hdr_idle) begin
			return;
		end
		emit             = 1'b0;
		v.status         = vhc_pkg::ST_OK;
		v.payload_size   = '0;
		v.bytes_consumed = '0;
		p                = int'(hdr_pos);
		if (p < vhc_pkg::POS_CRC_LO) begin
			crc_run = crc_step(crc_run, b);
		end
		if (p < vhc_pkg::POS_MAJOR) begin
			if (b != vhc_pkg::MAGIC[p]) begin
				emit     = 1'b1;
				v.status = vhc_pkg::ST_BAD_MAGIC;
			end
		end else if (p == vhc_pkg::POS_MAJOR) begin
			major_seen = b;
			if (b != vhc_pkg::MAJOR_SUPPORTED) begin
				emit     = 1'b1;
				v.status = vhc_pkg::ST_BAD_MAJOR;
			end
		end else if (p == vhc_pkg::POS_MINOR) begin
			minor_seen = b;
		end else if (p >= vhc_pkg::POS_SIZE_LO && p < vhc_pkg::POS_CRC_LO) begin
			size_seen = size_seen | (32'(b) << (8 * (p - vhc_pkg::POS_SIZE_LO)));
		end else if (p >= vhc_pkg::POS_CRC_LO) begin
			crc_seen = crc_seen | (32'(b) << (8 * (p - vhc_pkg::POS_CRC_LO)));
			if (p == vhc_pkg::POS_LAST) begin
				emit = 1'b1;
				if (crc_seen != ~crc_run) begin
					v.status = vhc_pkg::ST_BAD_CRC;
				end else if (minor_seen != vhc_pkg::MINOR_SUPPORTED) begin
					v.status = vhc_pkg::ST_BAD_MINOR;
				end else if (size_seen < bound_lo || size_seen > bound_hi) begin
					v.status = vhc_pkg::ST_BAD_SIZE;
				end else begin
					v.payload_size   = size_seen;
					v.bytes_consumed = vhc_pkg::HDR_LEN;
				end
			end
		end
		if (emit) begin
			v.major_version = major_seen;
			v.minor_version = minor_seen;
			awaited_verdicts.push_back(v);
			hdr_idle = 1'b1;
		end else begin
			hdr_pos = hdr_pos + 5'd1;
		end
	endfunction

	function automatic int draw_gap(input bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void build_frame(input logic [7:0] maj, input logic [7:0] mnr,
		input logic [31:0] size);
		logic [31:0] acc;
		int          k;
		for (k = 0; k < 4; k++) begin
			frame_bytes[k] = vhc_pkg::MAGIC[k];
		end
		frame_bytes[vhc_pkg::POS_MAJOR] = maj;
		frame_bytes[vhc_pkg::POS_MINOR] = mnr;
		frame_bytes[6]                  = 8'($urandom);
		frame_bytes[7]                  = 8'($urandom);
		for (k = 0; k < 4; k++) begin
			frame_bytes[vhc_pkg::POS_SIZE_LO + k] = size[8*k +: 8];
		end
		acc = vhc_pkg::CRC_INIT;
		for (k = 0; k < vhc_pkg::POS_CRC_LO; k++) begin
			acc = crc_step(acc, frame_bytes[k]);
		end
		acc = ~acc;
		for (k = 0; k < 4; k++) begin
			frame_bytes[vhc_pkg::POS_CRC_LO + k] = acc[8*k +: 8];
		end
	endfunction

	function automatic void push_loose(input logic start, input logic [7:0] data);
		hdr_byte_t b;
		b.start = start;
		b.data  = data;
		byte_queue.push_back(b);
	endfunction

	function automatic void send_frame(input int len);
		int k;
		for (k = 0; k < len; k++) begin
			push_loose(k == 0, frame_bytes[k]);
		end
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 7))
			0: begin
				return bound_lo;
			end
			1: begin
				return bound_hi;
			end
			2: begin
				return bound_lo - 32'd1;
			end
			3: begin
				return bound_hi + 32'd1;
			end
			4: begin
				return 32'($urandom_range(0, 255));
			end
			5: begin
				return 32'($urandom);
			end
			default: begin
				if (bound_lo <= bound_hi) begin
					return 32'($urandom_range(bound_hi, bound_lo));
				end
				return 32'($urandom);
			end
		endcase
	endfunction

	function automatic void queue_random_frame();
		int         kind;
		int         p;
		int         n;
		logic [7:0] maj;
		kind = $urandom_range(0, 99);
		if (kind < 56) begin
			build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, pick_size());
			send_frame(16);
			queued_bytes += 16;
		end else if (kind < 64) begin
			build_frame(vhc_pkg::MAJOR_SUPPORTED,
				$urandom_range(0, 1) ? vhc_pkg::MINOR_SUPPORTED : 8'($urandom),
				pick_size());
			p = vhc_pkg::POS_CRC_LO + $urandom_range(0, 3);
			frame_bytes[p] = frame_bytes[p] ^ 8'($urandom_range(1, 255));
			send_frame(16);
			queued_bytes += 16;
		end else if (kind < 72) begin
			build_frame(vhc_pkg::MAJOR_SUPPORTED, 8'($urandom_range(1, 255)), pick_size());
			send_frame(16);
			queued_bytes += 16;
		end else if (kind < 78) begin
			maj = 8'($urandom);
			if (maj == vhc_pkg::MAJOR_SUPPORTED) begin
				maj = 8'd0;
			end
			build_frame(maj, 8'($urandom), pick_size());
			n = $urandom_range(5, 16);
			send_frame(n);
			queued_bytes += n;
		end else if (kind < 84) begin
			p = $urandom_range(0, 3);
			build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, pick_size());
			frame_bytes[p] = frame_bytes[p] ^ 8'($urandom_range(1, 255));
			n = $urandom_range(p + 1, p + 4);
			send_frame(n);
			queued_bytes += n;
		end else if (kind < 92) begin
			build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, pick_size());
			n = $urandom_range(1, 15);
			send_frame(n);
			queued_bytes += n;
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				push_loose($urandom_range(0, 3) == 0, 8'($urandom));
			end
			queued_bytes += n;
		end
	endfunction

	task automatic write_bounds(input logic [31:0] lo, input logic [31:0] hi);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= vhc_pkg::REG_SIZE_MIN;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_idx   <= vhc_pkg::REG_SIZE_MAX;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
		bound_lo = lo;
		bound_hi = hi;
	endtask

	task automatic random_phase(input int n);
		int target;
		target = queued_bytes + n;
		while (queued_bytes < target) begin
			queue_random_frame();
		end
		do begin
			@(negedge clk);
		end while (byte_queue.size() != 0 || hdr.valid || awaited_verdicts.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] expected,
		input logic [31:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr.valid       <= 1'b0;
			hdr.data_byte   <= '0;
			hdr.frame_start <= 1'b0;
			gap_left        <= 0;
			calm_in         <= 1'b0;
		end else begin
			if (hdr.valid && hdr.ready) begin
				track_header_byte(hdr.frame_start, hdr.data_byte);
			end
			if (!hdr.valid || hdr.ready) begin
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					hdr.valid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					next_byte = byte_queue.pop_front();
					hdr.valid       <= 1'b1;
					hdr.data_byte   <= next_byte.data;
					hdr.frame_start <= next_byte.start;
					gap_left        <= draw_gap(calm_in);
				end else begin
					hdr.valid <= 1'b0;
				end
			end
			if ($urandom_range(0, 299) == 0) begin
				calm_in <= !calm_in;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready  <= 1'b0;
			stall_left <= 0;
			calm_out   <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (awaited_verdicts.size() == 0) begin
					$error("result with status %0d arrived with none expected", res.status);
					fail_count++;
				end else begin
					want = awaited_verdicts.pop_front();
					check_field("status", 32'(want.status), 32'(res.status));
					check_field("major_version", 32'(want.major_version), 32'(res.major_version));
					check_field("minor_version", 32'(want.minor_version), 32'(res.minor_version));
					check_field("payload_size", want.payload_size, res.payload_size);
					check_field("bytes_consumed", 32'(want.bytes_consumed),
						32'(res.bytes_consumed));
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				res.ready  <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				if ($urandom_range(0, 2) == 0) begin
					stall_left <= draw_gap(calm_out);
				end
			end
			if ($urandom_range(0, 299) == 0) begin
				calm_out <= !calm_out;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((hdr.valid && hdr.ready) || (res.valid && res.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [31:0] a;
		logic [31:0] b;
		int          p;
		hdr.valid       = 1'b0;
		hdr.data_byte   = '0;
		hdr.frame_start = 1'b0;
		res.ready       = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = vhc_pkg::REG_SIZE_MIN;
		cfg_wdata       = '0;
		arst_n          = 1'b0;
		bound_lo        = vhc_pkg::SIZE_MIN_RESET;
		bound_hi        = vhc_pkg::SIZE_MAX_RESET;
		hdr_pos         = '0;
		hdr_idle        = 1'b1;
		crc_run         = vhc_pkg::CRC_INIT;
		crc_seen        = '0;
		size_seen       = '0;
		major_seen      = '0;
		minor_seen      = '0;
		queued_bytes    = 0;
		fail_count      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed headers under the reset bounds.
		push_loose(1'b0, 8'hFF);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, 32'd1);
		send_frame(16);
		for (p = 0; p < 4; p++) begin
			build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, 32'd1);
			frame_bytes[p] = frame_bytes[p] ^ 8'hFF;
			send_frame(p + 1);
		end
		build_frame(8'h00, vhc_pkg::MINOR_SUPPORTED, 32'd1);
		send_frame(5);
		build_frame(8'hFF, vhc_pkg::MINOR_SUPPORTED, 32'd1);
		send_frame(5);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED,
			vhc_pkg::SIZE_MAX_RESET);
		send_frame(16);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED,
			vhc_pkg::SIZE_MAX_RESET + 32'd1);
		send_frame(16);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, 32'd0);
		send_frame(16);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, 8'hFF, 32'd100);
		send_frame(16);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, 8'h01, 32'd100);
		frame_bytes[vhc_pkg::POS_LAST] = frame_bytes[vhc_pkg::POS_LAST] ^ 8'h80;
		send_frame(16);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, 32'd5);
		send_frame(8);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, 32'd5);
		send_frame(16);
		push_loose(1'b0, 8'h00);
		push_loose(1'b0, 8'h42);
		push_loose(1'b0, 8'hFF);
		random_phase(345);

		write_bounds(32'd0, 32'hFFFF_FFFF);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, 32'd0);
		send_frame(16);
		build_frame(vhc_pkg::MAJOR_SUPPORTED, vhc_pkg::MINOR_SUPPORTED, 32'hFFFF_FFFF);
		send_frame(16);
		random_phase(345);

		a = 32'($urandom);
		write_bounds(a, a);
		random_phase(345);

		// Bounds the wrong way round reject every size.
		a = 32'($urandom);
		b = 32'($urandom);
		if (a == b) begin
			b = b ^ 32'd1;
		end
		write_bounds((a > b) ? a : b, (a > b) ? b : a);
		random_phase(345);

		a = 32'($urandom_range(0, 1000));
		b = 32'($urandom_range(32'h00FF_FFFF, a));
		write_bounds(a, b);
		random_phase(345);

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/vhc_pkg.sv
rtl/core/vhc_byte_if.sv
rtl/core/vhc_result_if.sv
rtl/core/vhc_parse_core.sv
rtl/core/versioned_header_checker.sv
test/tb_versioned_header_checker.sv
